FILE: design/rpi_pkg.sv
// Shared types, register codes and saturating fixed-point helpers for the ray/plane block.
package rpi_pkg;

  localparam int CW     = 32;          // coordinate width
  localparam int FW     = 16;          // fraction bits
  localparam int DIRW   = 18;          // direction component width
  localparam int LENW   = 31;          // length width
  localparam int TOLW   = 16;          // tolerance width
  localparam int SW     = CW + 2;      // width of a three-term sum
  localparam int PW     = 2 * CW;      // full product width
  localparam int PSW    = DIRW + CW;   // direction times length product width
  localparam int DW     = CW + FW;     // quotient width before saturation
  localparam int ADDR_W = 5;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t ONE = coord_t'(1) <<< FW;

  // register indexes (byte address bits [4:2])
  localparam logic [2:0] REG_NX  = 3'd0;
  localparam logic [2:0] REG_NY  = 3'd1;
  localparam logic [2:0] REG_NZ  = 3'd2;
  localparam logic [2:0] REG_OFS = 3'd3;
  localparam logic [2:0] REG_TOL = 3'd4;

  // result status codes
  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_PAR = 3'd1;
  localparam logic [2:0] ST_BEH = 3'd2;
  localparam logic [2:0] ST_BEY = 3'd3;
  localparam logic [2:0] ST_OFF = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic       inf;
    logic       neg;
    coord_t     sx;
    coord_t     sy;
    coord_t     sz;
    coord_t     px;
    coord_t     py;
    coord_t     pz;
  } div_meta_t;

  // floor shift by FW, then saturate to CW bits
  function automatic coord_t sat_prod(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    sh = p >>> FW;
    if ((&sh[PW-1:CW-1]) || !(|sh[PW-1:CW-1])) return sh[CW-1:0];
    return sh[PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic coord_t sat_sum(input logic signed [SW-1:0] v);
    if ((&v[SW-1:CW-1]) || !(|v[SW-1:CW-1])) return v[CW-1:0];
    return v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic logic signed [SW-1:0] ext(input coord_t v);
    return {{(SW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic [CW:0] mag(input coord_t v);
    logic [CW:0] e;
    e = {v[CW-1], v};
    return v[CW-1] ? (~e + 1'b1) : e;
  endfunction

endpackage

FILE: design/rpi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module rpi_div
  import rpi_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [CW-1:0]   in_num,
  input  logic [CW-1:0]   in_den,
  input  div_meta_t       in_meta,
  output logic            out_valid,
  output logic [DW-1:0]   out_quot,
  output div_meta_t       out_meta
);

  logic [CW-1:0] s_rem  [0:DW];
  logic [DW-1:0] s_quo  [0:DW];
  logic [CW-1:0] s_num  [0:DW];
  logic [CW-1:0] s_den  [0:DW];
  div_meta_t     s_meta [0:DW];
  logic          s_vld  [0:DW];

  assign s_rem[0]  = '0;
  assign s_quo[0]  = '0;
  assign s_num[0]  = in_num;
  assign s_den[0]  = in_den;
  assign s_meta[0] = in_meta;
  assign s_vld[0]  = in_valid;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          nbit;
    logic [CW:0]   trial;
    logic          ge;
    logic [CW-1:0] rem;
    logic [DW-1:0] quo;
    logic [CW-1:0] num;
    logic [CW-1:0] den;
    div_meta_t     meta;
    logic          vld;

    if (DW - 1 - k >= FW) begin : g_bit
      assign nbit = s_num[k][DW-1-k-FW];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign trial = {s_rem[k], nbit};
    assign ge    = trial >= {1'b0, s_den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (en) begin
        vld <= s_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem  <= ge ? CW'(trial - {1'b0, s_den[k]}) : trial[CW-1:0];
        quo  <= {s_quo[k][DW-2:0], ge};
        num  <= s_num[k];
        den  <= s_den[k];
        meta <= s_meta[k];
      end
    end

    assign s_rem[k+1]  = rem;
    assign s_quo[k+1]  = quo;
    assign s_num[k+1]  = num;
    assign s_den[k+1]  = den;
    assign s_meta[k+1] = meta;
    assign s_vld[k+1]  = vld;
  end

  assign out_valid = s_vld[DW];
  assign out_quot  = s_quo[DW];
  assign out_meta  = s_meta[DW];

endmodule

FILE: design/ray_plane_intersect_top.sv
// Top level of the ray/plane intersection pipeline with its register port.
//
// Each transfer on the input stream carries one segment, finite ray or infinite ray
// (tuser = mode) and yields exactly one result transfer, in order. The block is a
// fully pipelined datapath: it takes one item every clock cycle, and each item passes
// the front stages, the 48-stage restoring divider that forms t one quotient bit
// per stage, then the back stages and the output register. When the output is
// stalled the whole pipeline holds; nothing is dropped or repeated. All arithmetic
// is Q16.16: products are floored and saturated, the quotient is truncated toward
// zero and saturated. Status codes are 0 hit, 1 parallel, 2 behind start, 3 beyond
// end, 4 off plane; the point is zero for codes 1 to 3. Plane normal, offset and
// tolerance sit at byte addresses 0, 4, 8, 12 and 16 and are to be written only
// while no item is in flight.
module ray_plane_intersect_top
  import rpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [183:0]      s_axis_tdata,  // start_x, start_y, start_z, dir_x, dir_y,
                                           // dir_z, length, zero fill
  input  logic [1:0]        s_axis_tuser,  // mode
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [95:0]       m_axis_tdata,  // point_x, point_y, point_z
  output logic [3:0]        m_axis_tuser,  // hit, status
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // ---------------------------------------------------------------- registers
  coord_t            nrm [0:2];
  coord_t            ofs;
  logic [TOLW-1:0]   tol;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm[0] <= '0;
      nrm[1] <= '0;
      nrm[2] <= ONE;
      ofs    <= '0;
      tol    <= TOLW'(1);
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_NX:  nrm[0] <= pwdata;
        REG_NY:  nrm[1] <= pwdata;
        REG_NZ:  nrm[2] <= pwdata;
        REG_OFS: ofs    <= pwdata;
        REG_TOL: tol    <= pwdata[TOLW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_NX:  prdata = nrm[0];
      REG_NY:  prdata = nrm[1];
      REG_NZ:  prdata = nrm[2];
      REG_OFS: prdata = ofs;
      REG_TOL: prdata = {{(32-TOLW){1'b0}}, tol};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // Advance every stage whenever the output register is free or being taken.
  logic adv;
  logic out_vld;

  assign adv           = !out_vld || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------- input decode
  coord_t                 in_p [0:2];
  logic signed [DIRW-1:0] in_d [0:2];
  coord_t                 in_len;
  logic                   in_inf;

  assign in_p[0] = s_axis_tdata[31:0];
  assign in_p[1] = s_axis_tdata[63:32];
  assign in_p[2] = s_axis_tdata[95:64];
  assign in_d[0] = s_axis_tdata[113:96];
  assign in_d[1] = s_axis_tdata[131:114];
  assign in_d[2] = s_axis_tdata[149:132];
  // mode 2 and the unused mode 3 both act as an infinite ray
  assign in_inf  = s_axis_tuser[1];
  assign in_len  = in_inf ? ONE : {1'b0, s_axis_tdata[180:150]};

  // ---------------------------------------------------------------- front stages
  logic                  v1, v2, v3, v4, v5;
  logic signed [PSW-1:0] ps1 [0:2];
  logic signed [PW-1:0]  pn1 [0:2];
  coord_t                p1 [0:2], p2 [0:2], p3 [0:2], p4 [0:2], p5 [0:2];
  logic                  inf1, inf2, inf3, inf4, inf5;
  coord_t                sv2 [0:2], sv3 [0:2], sv4 [0:2], sv5 [0:2];
  coord_t                pn2 [0:2];
  logic signed [PW-1:0]  pd3 [0:2];
  coord_t                num3, num4, num5;
  coord_t                dt4 [0:2];
  coord_t                den5;
  coord_t                dotp;

  assign dotp = sat_sum(ext(pn2[0]) + ext(pn2[1]) + ext(pn2[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        // scale direction, project start point on the normal
        ps1[i] <= in_d[i] * in_len;
        pn1[i] <= in_p[i] * nrm[i];
        p1[i]  <= in_p[i];
        // floor and saturate
        sv2[i] <= sat_prod({{(PW-PSW){ps1[i][PSW-1]}}, ps1[i]});
        pn2[i] <= sat_prod(pn1[i]);
        p2[i]  <= p1[i];
        // project scaled direction
        pd3[i] <= sv2[i] * nrm[i];
        sv3[i] <= sv2[i];
        p3[i]  <= p2[i];
        dt4[i] <= sat_prod(pd3[i]);
        sv4[i] <= sv3[i];
        p4[i]  <= p3[i];
        sv5[i] <= sv4[i];
        p5[i]  <= p4[i];
      end
      inf1 <= in_inf;
      inf2 <= inf1;
      inf3 <= inf2;
      inf4 <= inf3;
      inf5 <= inf4;
      num3 <= sat_sum(-ext(dotp) - ext(ofs));
      num4 <= num3;
      num5 <= num4;
      den5 <= sat_sum(ext(dt4[0]) + ext(dt4[1]) + ext(dt4[2]));
    end
  end

  // ---------------------------------------------------------------- divider
  div_meta_t     dmi, dmo;
  logic [CW:0]   num_mag, den_mag;
  logic          dv;
  logic [DW-1:0] quot;

  assign num_mag = mag(num5);
  assign den_mag = mag(den5);

  always_comb begin
    dmi.status = (den_mag <= {{(CW+1-TOLW){1'b0}}, tol}) ? ST_PAR : ST_HIT;
    dmi.inf    = inf5;
    dmi.neg    = num5[CW-1] ^ den5[CW-1];
    dmi.sx     = sv5[0];
    dmi.sy     = sv5[1];
    dmi.sz     = sv5[2];
    dmi.px     = p5[0];
    dmi.py     = p5[1];
    dmi.pz     = p5[2];
  end

  rpi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v5),
    .in_num    (num_mag[CW-1:0]),
    .in_den    (den_mag[CW-1:0]),
    .in_meta   (dmi),
    .out_valid (dv),
    .out_quot  (quot),
    .out_meta  (dmo)
  );

  // ---------------------------------------------------------------- back stages
  logic [DW-1:0] lim;
  coord_t        t_w;
  logic [2:0]    st_w;

  // saturate the magnitude, then apply the sign
  assign lim = {{(DW-CW){1'b0}}, dmo.neg, {(CW-1){~dmo.neg}}};

  always_comb begin
    if (quot > lim) begin
      t_w = dmo.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      t_w = dmo.neg ? -quot[CW-1:0] : quot[CW-1:0];
    end
    if (dmo.status == ST_PAR) begin
      st_w = ST_PAR;
    end else if (t_w <= 0) begin
      st_w = ST_BEH;
    end else if (!dmo.inf && t_w >= ONE) begin
      st_w = ST_BEY;
    end else begin
      st_w = ST_HIT;
    end
  end

  logic                 v6, v7, v8, v9, v10;
  coord_t               t6;
  logic [2:0]           st6, st7, st8, st9, st10;
  coord_t               sv6 [0:2];
  coord_t               p6 [0:2], p7 [0:2];
  logic signed [PW-1:0] pt7 [0:2];
  coord_t               h8 [0:2], h9 [0:2], h10 [0:2];
  logic signed [PW-1:0] ph9 [0:2];
  coord_t               hn10 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (adv) begin
      v6  <= dv;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t6     <= t_w;
      st6    <= st_w;
      sv6[0] <= dmo.sx;
      sv6[1] <= dmo.sy;
      sv6[2] <= dmo.sz;
      p6[0]  <= dmo.px;
      p6[1]  <= dmo.py;
      p6[2]  <= dmo.pz;
      for (int i = 0; i < 3; i++) begin
        pt7[i]  <= t6 * sv6[i];
        p7[i]   <= p6[i];
        h8[i]   <= sat_sum(ext(sat_prod(pt7[i])) + ext(p7[i]));
        ph9[i]  <= h8[i] * nrm[i];
        h9[i]   <= h8[i];
        hn10[i] <= sat_prod(ph9[i]);
        h10[i]  <= h9[i];
      end
      st7  <= st6;
      st8  <= st7;
      st9  <= st8;
      st10 <= st9;
    end
  end

  // ---------------------------------------------------------------- residual and output
  coord_t      dot_h, res;
  logic [CW:0] res_mag;
  logic [2:0]  st_f;
  logic        keep;

  assign dot_h   = sat_sum(ext(hn10[0]) + ext(hn10[1]) + ext(hn10[2]));
  assign res     = sat_sum(ext(dot_h) + ext(ofs));
  assign res_mag = mag(res);
  assign keep    = st10 == ST_HIT;

  always_comb begin
    if (!keep) begin
      st_f = st10;
    end else if (res_mag <= {{(CW+1-TOLW){1'b0}}, tol}) begin
      st_f = ST_HIT;
    end else begin
      st_f = ST_OFF;
    end
  end

  coord_t     o_pt [0:2];
  logic [2:0] o_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_st <= st_f;
      for (int i = 0; i < 3; i++) begin
        // drop the point for early rejections
        o_pt[i] <= keep ? h10[i] : '0;
      end
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {o_pt[2], o_pt[1], o_pt[0]};
  assign m_axis_tuser  = {o_st, o_st == ST_HIT};

`ifndef SYNTHESIS
  a_hit_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[3:1] == ST_HIT)))
    else $error("hit flag disagrees with status");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[3:1] == ST_PAR || m_axis_tuser[3:1] == ST_BEH ||
     m_axis_tuser[3:1] == ST_BEY)) |-> (m_axis_tdata == '0))
    else $error("early rejection carries a point");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(v1) && $stable(v5) && $stable(v10) && $stable(o_st)))
    else $error("pipeline moved during a stall");
`endif

endmodule
